// ===== rtl/hvae_pkg.sv =====
package hvae_pkg;

  // fixed voice configuration
  localparam int AUDIO_RATE_HZ    = 48000;
  localparam int PHASE_BITS       = 24;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int QUAD_BITS   = PHASE_BITS - 2;
  localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int ENV_W       = 24;

  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1) << 23;

  // envelope steps, rounded at elaboration
  localparam logic [63:0] ATTACK_FULL =
    ((64'd1 << 23) * 64'd2000 + (64'd3 * AUDIO_RATE_HZ) / 64'd2) / (64'd3 * AUDIO_RATE_HZ);
  localparam logic [63:0] RELEASE_FULL =
    ((64'd1 << 23) * 64'd50 + (64'd9 * AUDIO_RATE_HZ) / 64'd2) / (64'd9 * AUDIO_RATE_HZ);
  localparam logic [ENV_W-1:0] ATTACK_STEP  = ATTACK_FULL[ENV_W-1:0];
  localparam logic [ENV_W-1:0] RELEASE_STEP = RELEASE_FULL[ENV_W-1:0];

  // harmonic weights, Q0.15
  localparam logic [14:0] W_H1 = 15'd24576;
  localparam logic [14:0] W_H2 = 15'd6554;
  localparam logic [14:0] W_H3 = 15'd1638;

  // output scaling: divide by 1270 after dropping 38 bits
  localparam logic [25:0] ROUND_HALF = 26'd635;
  localparam logic [25:0] DIV_OUT    = 26'd1270;
  localparam logic [25:0] CLIP_X     = 26'd41615360;
  localparam logic [16:0] RECIP_OUT  = 17'd52841;
  localparam int          RECIP_OUT_SH = 26;

  // activity average: divide by 100
  localparam logic [21:0] DIV_ACT      = 22'd100;
  localparam logic [16:0] RECIP_ACT    = 17'd41943;
  localparam int          RECIP_ACT_SH = 22;
  localparam logic [16:0] LEAK_MUL     = 17'd99;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [31:0] SEMITONE_Q30 [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };
  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ENV, S_ADDR, S_MAC, S_MAG, S_ELO, S_EHI,
    S_DQ, S_DR, S_AM, S_AQ, S_AR, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] note;
    logic [6:0] velocity;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [14:0]        activity;
    logic               active;
    logic [6:0]         current_note;
  } res_t;

  typedef struct packed {
    logic is_tick;
    logic voice_on;
    logic ended;
    logic clip;
    logic last_harm;
    logic res_free;
  } status_t;

  typedef struct packed {
    state_t state;
    logic   ready;
    logic   accept;
    logic   load_res;
  } ctrl_t;

  typedef logic [PHASE_BITS-1:0] step_rom_t [128];
  typedef logic [14:0] sine_rom_t [SINE_TABLE_DEPTH + 1];

  // phase step per note, round(f * 2^PHASE_BITS / AUDIO_RATE_HZ)
  function automatic step_rom_t build_steps();
    step_rom_t   rom;
    int          shifted;
    int          octave;
    int          semi;
    int          sh;
    logic [63:0] f;
    logic [63:0] q;
    logic [63:0] v;
    for (int n = 0; n < 128; n++) begin
      shifted = n + 3;
      octave  = shifted / 12 - 6;
      semi    = shifted % 12;
      f       = (64'd440 * 64'(SEMITONE_Q30[semi])) << 16;
      q       = f / AUDIO_RATE_HZ;
      sh      = 46 - PHASE_BITS - octave;
      v       = (q + (64'd1 << (sh - 1))) >> sh;
      rom[n]  = v[PHASE_BITS-1:0];
    end
    return rom;
  endfunction

  // quarter sine, integer taylor series in Q2.30
  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x  = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int k = 0; k < 5; k++) begin
        t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[k];
      end
      v = (((x * t) >> 30) + 64'd16384) >> 15;
      rom[i] = (v > 64'd32767) ? 15'd32767 : v[14:0];
    end
    return rom;
  endfunction

  localparam step_rom_t STEP_ROM = build_steps();

endpackage

// ===== rtl/hvae_sine_rom.sv =====
module hvae_sine_rom (
  input  logic                             clk,
  input  logic [hvae_pkg::SINE_ADDR_W-1:0] addr,
  output logic [14:0]                      data
);
  import hvae_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine();

  // registered read
  always_ff @(posedge clk) begin
    data <= SINE_ROM[addr];
  end

endmodule

// ===== rtl/hvae_seq.sv =====
module hvae_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  hvae_pkg::status_t st,
  output hvae_pkg::ctrl_t   ctrl
);
  import hvae_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && st.is_tick) begin
          state_next = st.voice_on ? S_ENV : S_DONE;
        end
      end
      S_ENV:  state_next = st.ended ? S_DONE : S_ADDR;
      S_ADDR: state_next = S_MAC;
      S_MAC:  state_next = st.last_harm ? S_MAG : S_ADDR;
      S_MAG:  state_next = S_ELO;
      S_ELO:  state_next = S_EHI;
      S_EHI:  state_next = S_DQ;
      S_DQ:   state_next = st.clip ? S_AM : S_DR;
      S_DR:   state_next = S_AM;
      S_AM:   state_next = S_AQ;
      S_AQ:   state_next = S_AR;
      S_AR:   state_next = S_DONE;
      S_DONE: begin
        if (st.res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl.state    = state;
    ctrl.ready    = (state == S_IDLE);
    ctrl.accept   = (state == S_IDLE) && cmd_valid;
    ctrl.load_res = (state == S_DONE) && st.res_free;
  end

endmodule

// ===== rtl/harmonic_voice_with_ar_envelope.sv =====
// one voice: start, release and unused items are taken in the idle state, no result
// a sounding tick is loaded into the result register after it is taken, after
// three table reads and 11 steps of the shared multiplier (the remainder step is
// skipped when the output clips); a tick that ends the voice or finds it silent
// skips that work; the load waits while the result register is full; the next item is taken the cycle after the load
// reset (synchronous) clears phase, envelope, activity and voice state
module harmonic_voice_with_ar_envelope (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  hvae_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output hvae_pkg::res_t res
);
  import hvae_pkg::*;

  // voice state
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_step;
  logic [ENV_W-1:0]      envelope;
  logic [6:0]            velocity_level;
  logic [14:0]           activity_level;
  logic                  voice_on;
  logic                  in_release;
  logic [6:0]            held_note;

  // work registers
  logic [1:0]         hcnt;
  logic signed [31:0] h_acc;
  logic               neg;
  logic [39:0]        m;
  logic [63:0]        p;
  logic [15:0]        qe;
  logic [14:0]        mag;
  logic [21:0]        y;
  logic signed [15:0] sample_r;

  status_t st;
  ctrl_t   ctrl;

  hvae_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .st        (st),
    .ctrl      (ctrl)
  );

  assign cmd_ready = ctrl.ready;

  // envelope step
  logic [ENV_W:0]   env_sum;
  logic [ENV_W-1:0] env_attack;
  logic             ended;
  assign env_sum    = {1'b0, envelope} + {1'b0, ATTACK_STEP};
  assign env_attack = (env_sum > {1'b0, ENV_ONE}) ? ENV_ONE : env_sum[ENV_W-1:0];
  assign ended      = in_release && (envelope <= RELEASE_STEP);

  // harmonic phase and table address
  logic [PHASE_BITS-1:0]           p2;
  logic [PHASE_BITS-1:0]           p3;
  logic [PHASE_BITS-1:0]           hp;
  logic [1:0]                      quad;
  logic [QUAD_BITS+SINE_ADDR_W-1:0] idx_full;
  logic [SINE_ADDR_W-1:0]          idx;
  logic [SINE_ADDR_W-1:0]          rom_addr;
  logic [14:0]                     rom_data;
  logic signed [16:0]              sv;
  logic [14:0]                     weight;

  assign p2 = {phase_acc[PHASE_BITS-2:0], 1'b0};
  assign p3 = phase_acc + p2;
  always_comb begin
    unique case (hcnt)
      2'd0:    begin hp = phase_acc; weight = W_H1; end
      2'd1:    begin hp = p2;        weight = W_H2; end
      default: begin hp = p3;        weight = W_H3; end
    endcase
  end
  assign quad     = hp[PHASE_BITS-1:PHASE_BITS-2];
  assign idx_full = (QUAD_BITS+SINE_ADDR_W)'(hp[QUAD_BITS-1:0])
                    * (QUAD_BITS+SINE_ADDR_W)'(SINE_TABLE_DEPTH);
  assign idx      = idx_full[QUAD_BITS+SINE_ADDR_W-1:QUAD_BITS];
  assign rom_addr = quad[0] ? (SINE_ADDR_W'(SINE_TABLE_DEPTH) - idx) : idx;

  hvae_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign sv = quad[1] ? -$signed({2'b00, rom_data}) : $signed({2'b00, rom_data});

  // shared multiplier operand select
  logic [8:0]         v3;
  logic [30:0]        h_abs;
  logic [25:0]        x;
  logic signed [40:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [57:0] prod;

  assign v3    = ({2'b00, velocity_level} << 1) + {2'b00, velocity_level};
  assign h_abs = h_acc[31] ? 31'(-h_acc) : h_acc[30:0];
  assign x     = p[63:38] + ROUND_HALF;

  always_comb begin
    unique case (ctrl.state)
      S_MAC:   begin mul_a = $signed(41'(weight)); mul_b = sv; end
      S_MAG:   begin mul_a = $signed(41'(h_abs));  mul_b = $signed(17'(v3)); end
      S_ELO:   begin mul_a = $signed(41'(m));      mul_b = $signed(17'(envelope[11:0])); end
      S_EHI:   begin mul_a = $signed(41'(m));      mul_b = $signed(17'(envelope[23:12])); end
      S_DQ:    begin mul_a = $signed(41'(x));      mul_b = $signed(RECIP_OUT); end
      S_DR:    begin mul_a = $signed(41'(qe));     mul_b = $signed(17'(DIV_OUT)); end
      S_AM:    begin mul_a = $signed(41'(activity_level)); mul_b = $signed(LEAK_MUL); end
      S_AQ:    begin mul_a = $signed(41'(y));      mul_b = $signed(RECIP_ACT); end
      S_AR:    begin mul_a = $signed(41'(qe));     mul_b = $signed(17'(DIV_ACT)); end
      default: begin mul_a = '0;                   mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // quotient corrections
  logic [25:0] r_out;
  logic [14:0] mag_q;
  logic [21:0] r_act;
  logic [14:0] act_q;
  assign r_out = x - prod[25:0];
  assign mag_q = (r_out >= DIV_OUT) ? 15'(qe + 16'd1) : qe[14:0];
  assign r_act = y - prod[21:0];
  assign act_q = (r_act >= DIV_ACT) ? 15'(qe + 16'd1) : qe[14:0];

  // status to the sequencer
  logic res_free;
  assign res_free     = !res_valid || res_ready;
  assign st.is_tick   = (cmd.operation == OP_TICK);
  assign st.voice_on  = voice_on;
  assign st.ended     = ended;
  assign st.clip      = (x >= CLIP_X);
  assign st.last_harm = (hcnt == 2'd2);
  assign st.res_free  = res_free;

  // voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc      <= '0;
      phase_step     <= '0;
      envelope       <= '0;
      velocity_level <= '0;
      activity_level <= '0;
      voice_on       <= 1'b0;
      in_release     <= 1'b0;
      held_note      <= '0;
    end else begin
      if (ctrl.accept && cmd.operation == OP_START) begin
        voice_on       <= 1'b1;
        in_release     <= 1'b0;
        held_note      <= cmd.note;
        velocity_level <= cmd.velocity;
        phase_acc      <= '0;
        envelope       <= '0;
        activity_level <= '0;
        phase_step     <= STEP_ROM[cmd.note];
      end else if (ctrl.accept && cmd.operation == OP_RELEASE) begin
        in_release <= 1'b1;
      end
      if (ctrl.state == S_ENV) begin
        if (ended) begin
          envelope       <= '0;
          voice_on       <= 1'b0;
          activity_level <= '0;
        end else if (in_release) begin
          envelope <= envelope - RELEASE_STEP;
        end else begin
          envelope <= env_attack;
        end
      end
      if (ctrl.state == S_AR) begin
        activity_level <= act_q;
        phase_acc      <= phase_acc + phase_step;
      end
    end
  end

  // arithmetic sequence
  always_ff @(posedge clk) begin
    unique case (ctrl.state)
      S_IDLE: begin
        sample_r <= '0;
      end
      S_ENV: begin
        hcnt     <= 2'd0;
        h_acc    <= '0;
        sample_r <= '0;
      end
      S_MAC: begin
        h_acc <= h_acc + prod[31:0];
        hcnt  <= hcnt + 2'd1;
      end
      S_MAG: begin
        m   <= prod[39:0];
        neg <= h_acc[31];
      end
      S_ELO: begin
        p <= 64'(prod[51:0]);
      end
      S_EHI: begin
        p <= p + (64'(prod[51:0]) << 12);
      end
      S_DQ: begin
        if (x >= CLIP_X) begin
          mag <= 15'd32767;
        end else begin
          qe <= prod[RECIP_OUT_SH+15:RECIP_OUT_SH];
        end
      end
      S_DR: begin
        mag <= mag_q;
      end
      S_AM: begin
        y        <= prod[21:0] + 22'(mag);
        sample_r <= (neg && mag != '0) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      S_AQ: begin
        qe <= prod[RECIP_ACT_SH+15:RECIP_ACT_SH];
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_res) begin
      res.sample       <= sample_r;
      res.activity     <= activity_level;
      res.active       <= voice_on;
      res.current_note <= held_note;
    end
  end

  // checks
  a_start_on: assert property (@(posedge clk) disable iff (rst)
    (ctrl.accept && cmd.operation == OP_START) |=> voice_on)
    else $error("voice not on after start");

  a_env_max: assert property (@(posedge clk) disable iff (rst)
    envelope <= ENV_ONE)
    else $error("envelope above one");

  a_silent_env: assert property (@(posedge clk) disable iff (rst)
    !voice_on |-> envelope == '0)
    else $error("envelope nonzero while voice off");

  a_sound_active: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.sample != '0) |-> res.active)
    else $error("sound from inactive voice");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hvae_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [23:0] PMASK = 24'hFFFFFF;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;

  harmonic_voice_with_ar_envelope uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // voice model state
  logic [23:0] m_phase;
  logic [23:0] m_step;
  logic [23:0] m_env;
  logic [6:0]  m_vel;
  logic [14:0] m_act;
  logic        m_on;
  logic        m_rel;
  logic [6:0]  m_note;
  logic [14:0] qsine [SINE_TABLE_DEPTH + 1];

  cmd_t pending_cmds[$];
  res_t expected_samples[$];
  int   error_count;
  int   cycle_count;
  logic idle_free;

  // quarter sine table, own integer series
  task automatic fill_sine();
    logic [63:0] x, x2, t, v;
    logic [63:0] dv [5];
    dv = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x  = (64'(i) * 64'd1686629713) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int k = 0; k < 5; k++) t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[k];
      v = (((x * t) >> 30) + 64'd16384) >> 15;
      qsine[i] = (v > 64'd32767) ? 15'd32767 : v[14:0];
    end
  endtask

  function automatic logic [23:0] note_phase_step(logic [6:0] n);
    logic [31:0] semis [12];
    int sh, octave, s;
    logic [63:0] q;
    semis = '{32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
              32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
              32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652};
    s = int'(n) + 3;
    octave = s / 12 - 6;
    q = ((64'd440 * 64'(semis[s % 12])) << 16) / 64'd48000;
    sh = 22 - octave;
    q = (q + (64'd1 << (sh - 1))) >> sh;
    return q[23:0];
  endfunction

  function automatic longint sine_at(logic [23:0] p);
    logic [63:0] idx;
    longint v;
    idx = (64'(p[21:0]) * SINE_TABLE_DEPTH) >> 22;
    if (idx >= SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH - 1;
    v = p[22] ? longint'(qsine[SINE_TABLE_DEPTH - idx]) : longint'(qsine[idx]);
    return p[23] ? -v : v;
  endfunction

  // advance the voice for one command, queue the sample for ticks
  task automatic voice_apply(cmd_t c);
    logic [23:0] atk, rls;
    longint h;
    logic [127:0] mag;
    logic [127:0] den;
    logic neg, ended;
    res_t r;
    atk = 24'(((64'd1 << 23) * 2000 + 72000) / 144000);
    rls = 24'(((64'd1 << 23) * 50 + 216000) / 432000);
    neg = 1'b0;
    mag = '0;
    ended = 1'b0;
    case (c.operation)
      OP_START: begin
        m_on = 1; m_rel = 0; m_note = c.note; m_vel = c.velocity;
        m_phase = 0; m_env = 0; m_act = 0;
        m_step = note_phase_step(c.note);
      end
      OP_RELEASE: m_rel = 1;
      OP_TICK: begin
        if (m_on) begin
          if (m_rel) begin
            if (m_env <= rls) begin
              m_env = 0; m_on = 0; m_act = 0; ended = 1;
            end else begin
              m_env = m_env - rls;
            end
          end else begin
            m_env = (m_env + atk > 24'h800000) ? 24'h800000 : m_env + atk;
          end
          if (!ended) begin
            h = 24576 * sine_at(m_phase) + 6554 * sine_at((m_phase * 2) & PMASK)
              + 1638 * sine_at((m_phase * 3) & PMASK);
            neg = h < 0;
            mag = neg ? 128'(-h) : 128'(h);
            mag = mag * m_vel * 3 * m_env;
            den = 128'd1270 << 38;
            mag = (mag + den / 2) / den;
            if (mag > 32767) mag = 32767;
            if (mag == 0) neg = 0;
            m_act = 15'((99 * 64'(m_act) + 64'(mag)) / 100);
            m_phase = m_phase + m_step;
          end
        end
        r.sample = neg ? -16'(mag) : 16'(mag);
        r.activity = m_act;
        r.active = m_on;
        r.current_note = m_note;
        expected_samples.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic cmd_t make_cmd(logic [1:0] op, int n, int v);
    cmd_t c;
    c.operation = op;
    c.note = 7'(n);
    c.velocity = 7'(v);
    return c;
  endfunction

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_ready) begin
      if (cmd_valid && cmd_ready) voice_apply(cmd);
      if (pending_cmds.size() > 0 && (idle_free || $urandom_range(99) >= 16)) begin
        cmd <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = expected_samples.pop_front();
          if (res.sample !== want.sample)
            report_mismatch("sample", res.sample, want.sample);
          if (res.activity !== want.activity)
            report_mismatch("activity", res.activity, want.activity);
          if (res.active !== want.active)
            report_mismatch("active", res.active, want.active);
          if (res.current_note !== want.current_note)
            report_mismatch("current_note", res.current_note, want.current_note);
        end
      end
      res_ready <= idle_free || ($urandom_range(99) >= 16);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int r;
    cmd = '0;
    cmd_valid = 1'b0;
    res_ready = 1'b0;
    rst = 1'b1;
    error_count = 0;
    cycle_count = 0;
    idle_free = 1'b0;
    m_phase = 0; m_step = 0; m_env = 0; m_vel = 0;
    m_act = 0; m_on = 0; m_rel = 0; m_note = 0;
    fill_sine();

    // directed: silent tick, early release, extremes, unused operation, release while sounding
    pending_cmds.push_back(make_cmd(OP_TICK, 0, 0));
    pending_cmds.push_back(make_cmd(OP_RELEASE, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TICK, 0, 0));
    pending_cmds.push_back(make_cmd(OP_START, 127, 127));
    repeat (4) pending_cmds.push_back(make_cmd(OP_TICK, 0, 0));
    pending_cmds.push_back(make_cmd(2'd3, 127, 127));
    pending_cmds.push_back(make_cmd(OP_START, 0, 0));
    repeat (2) pending_cmds.push_back(make_cmd(OP_TICK, 0, 0));
    pending_cmds.push_back(make_cmd(OP_START, 69, 127));
    repeat (5) pending_cmds.push_back(make_cmd(OP_TICK, 0, 0));
    pending_cmds.push_back(make_cmd(OP_RELEASE, 85, 42));
    repeat (4) pending_cmds.push_back(make_cmd(OP_TICK, 0, 0));

    // random: note lives with attack, release and ending, plus noise
    while (pending_cmds.size() < 640) begin
      r = $urandom_range(9);
      if (r < 7) begin
        pending_cmds.push_back(make_cmd(OP_START, $urandom_range(127),
                                        $urandom_range(127)));
        repeat ($urandom_range(130)) begin
          if (pending_cmds.size() < 648)
            pending_cmds.push_back(make_cmd(OP_TICK, $urandom, $urandom));
        end
        pending_cmds.push_back(make_cmd(OP_RELEASE, $urandom, $urandom));
        repeat ($urandom_range(60)) begin
          if (pending_cmds.size() < 648)
            pending_cmds.push_back(make_cmd(OP_TICK, $urandom, $urandom));
        end
      end else begin
        pending_cmds.push_back(make_cmd(2'($urandom_range(3)), $urandom, $urandom));
        pending_cmds.push_back(make_cmd(OP_TICK, $urandom, $urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // hold no-idle stretch for part of the run
    idle_free = 1'b0;
    repeat (3000) @(posedge clk);
    idle_free = 1'b1;
    repeat (3000) @(posedge clk);
    idle_free = 1'b0;

    while (pending_cmds.size() > 0 || cmd_valid) @(negedge clk);
    while (expected_samples.size() > 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hvae_pkg.sv
rtl/hvae_sine_rom.sv
rtl/hvae_seq.sv
rtl/harmonic_voice_with_ar_envelope.sv
dv/testbench.sv
